@@ rtl/crar_pkg.sv @@
package crar_pkg;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TIMEOUT  = 1'b0,
    REG_ATTEMPTS = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd300;
  localparam logic [3:0]  ATTEMPTS_RESET = 4'd5;

  localparam logic [12:0] RECIP_10 = 13'd6554;

  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_STAT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic conv_step;
    logic emit_load;
    logic stat_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic send_now;
    logic digit_last;
    logic frame_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] rts_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_BANG;
      2'd1:    ch = CH_R;
      2'd2:    ch = CH_T;
      default: ch = CH_S;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ok_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_BANG;
      2'd1:    ch = CH_O;
      2'd2:    ch = CH_K;
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/crar_ctrl.sv @@
module crar_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  crar_pkg::dp_status_t  status,
  output crar_pkg::ctrl_cmd_t   cmd
);

  crar_pkg::ctrl_state_t state;
  crar_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crar_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = status.send_now ? crar_pkg::ST_CONV : crar_pkg::ST_STAT;
        end
      end
      crar_pkg::ST_CONV: begin
        if (status.digit_last) begin
          state_next = crar_pkg::ST_EMIT;
        end
      end
      crar_pkg::ST_EMIT: begin
        if (status.out_free && status.frame_last) begin
          state_next = crar_pkg::ST_IDLE;
        end
      end
      crar_pkg::ST_STAT: begin
        if (status.out_free) begin
          state_next = crar_pkg::ST_IDLE;
        end
      end
      default: state_next = crar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      crar_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.accept    = s_axis_tvalid;
      end
      crar_pkg::ST_CONV: cmd.conv_step = 1'b1;
      crar_pkg::ST_EMIT: cmd.emit_load = status.out_free;
      crar_pkg::ST_STAT: cmd.stat_load = status.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load || cmd.stat_load) |-> status.out_free)
    else $error("output register loaded while occupied");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !s_axis_tready)
    else $error("new transaction taken before previous one finished");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state != crar_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("input ready outside idle");
`endif

endmodule

@@ rtl/crar_dpath.sv @@
module crar_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crar_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [crar_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                opcode,
  input  logic [7:0]                          rx_byte,
  input  logic [11:0]                         sample,
  input  crar_pkg::ctrl_cmd_t                 cmd,
  output crar_pkg::dp_status_t                status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                tx_valid,
  output logic [7:0]                          tx_byte,
  output logic                                last,
  output logic                                led_on,
  output logic                                awaiting_ack,
  output logic [3:0]                          sends_done
);

  logic [15:0] timeout_ticks;
  logic [3:0]  max_attempts;

  logic        in_command,   in_command_next;
  logic [2:0]  match_pos,    match_pos_next;
  logic        still_rts,    still_rts_next;
  logic        still_ok,     still_ok_next;
  logic        link_busy,    link_busy_next;
  logic [3:0]  send_count,   send_count_next;
  logic [15:0] timer_left,   timer_left_next;
  logic        timer_armed,  timer_armed_next;
  logic [11:0] held_sample,  held_sample_next;
  logic        indicator,    indicator_next;

  logic        send_now;
  logic [11:0] send_sample;
  logic [3:0]  count_inc;

  logic [11:0] conv_v;
  logic [2:0]  dig_count;
  logic [3:0]  digits [4];
  logic [24:0] prod;
  logic [8:0]  quot;
  logic [11:0] quot_w;
  logic [11:0] tens;
  logic [11:0] rem_w;

  logic [3:0]  frame_idx;
  logic [3:0]  dig_sel;
  logic [7:0]  frame_byte;
  logic        frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= crar_pkg::TIMEOUT_RESET;
      max_attempts  <= crar_pkg::ATTEMPTS_RESET;
    end else if (cfg_we) begin
      unique case (crar_pkg::cfg_reg_t'(cfg_addr))
        crar_pkg::REG_TIMEOUT:  timeout_ticks <= cfg_wdata;
        crar_pkg::REG_ATTEMPTS: max_attempts  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // send decision for the transaction being taken
  always_comb begin
    send_now = 1'b0;
    if (!opcode) begin
      send_now = in_command && (rx_byte == crar_pkg::CH_HASH) && still_rts &&
                 (match_pos == 3'd4) && !link_busy;
    end else begin
      send_now = timer_armed && (timer_left <= 16'd1) && link_busy &&
                 (send_count < max_attempts);
    end
  end

  assign send_sample = opcode ? held_sample : sample;
  assign count_inc   = send_count + 4'd1;

  always_comb begin
    in_command_next  = in_command;
    match_pos_next   = match_pos;
    still_rts_next   = still_rts;
    still_ok_next    = still_ok;
    link_busy_next   = link_busy;
    send_count_next  = send_count;
    timer_left_next  = timer_left;
    timer_armed_next = timer_armed;
    held_sample_next = held_sample;
    indicator_next   = indicator;
    if (!opcode) begin
      if (!in_command) begin
        if (rx_byte == crar_pkg::CH_BANG) begin
          in_command_next = 1'b1;
          match_pos_next  = 3'd1;
          still_rts_next  = 1'b1;
          still_ok_next   = 1'b1;
        end
      end else if (rx_byte != crar_pkg::CH_HASH) begin
        still_rts_next = still_rts && (match_pos < 3'd4) &&
                         (rx_byte == crar_pkg::rts_char(match_pos[1:0]));
        still_ok_next  = still_ok && (match_pos < 3'd3) &&
                         (rx_byte == crar_pkg::ok_char(match_pos[1:0]));
        if (match_pos < 3'd7) begin
          match_pos_next = match_pos + 3'd1;
        end
      end else begin
        in_command_next = 1'b0;
        match_pos_next  = 3'd0;
        still_rts_next  = 1'b0;
        still_ok_next   = 1'b0;
        if (send_now) begin
          indicator_next   = 1'b0;
          held_sample_next = sample;
          link_busy_next   = 1'b1;
        end else if (still_ok && (match_pos == 3'd3) && link_busy) begin
          indicator_next   = 1'b1;
          link_busy_next   = 1'b0;
          send_count_next  = 4'd0;
          timer_left_next  = 16'd0;
          timer_armed_next = 1'b0;
        end
      end
    end else if (timer_armed) begin
      if (timer_left > 16'd1) begin
        timer_left_next = timer_left - 16'd1;
      end else begin
        timer_left_next  = 16'd0;
        timer_armed_next = 1'b0;
      end
    end
    if (send_now) begin
      // a fresh request restarts the count at zero before this send
      send_count_next = opcode ? count_inc : 4'd1;
      if (send_count_next < max_attempts) begin
        timer_left_next  = timeout_ticks;
        timer_armed_next = 1'b1;
      end else begin
        timer_left_next  = 16'd0;
        timer_armed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_command  <= 1'b0;
      match_pos   <= 3'd0;
      still_rts   <= 1'b0;
      still_ok    <= 1'b0;
      link_busy   <= 1'b0;
      send_count  <= 4'd0;
      timer_left  <= 16'd0;
      timer_armed <= 1'b0;
      held_sample <= 12'd0;
      indicator   <= 1'b0;
    end else if (cmd.accept) begin
      in_command  <= in_command_next;
      match_pos   <= match_pos_next;
      still_rts   <= still_rts_next;
      still_ok    <= still_ok_next;
      link_busy   <= link_busy_next;
      send_count  <= send_count_next;
      timer_left  <= timer_left_next;
      timer_armed <= timer_armed_next;
      held_sample <= held_sample_next;
      indicator   <= indicator_next;
    end
  end

  // decimal conversion, one digit per cycle, least significant first
  assign prod   = 25'(conv_v) * 25'(crar_pkg::RECIP_10);
  assign quot   = prod[24:16];
  assign quot_w = {3'd0, quot};
  assign tens   = (quot_w << 3) + (quot_w << 1);
  assign rem_w  = conv_v - tens;

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_count <= 3'd0;
      frame_idx <= 4'd0;
    end else if (cmd.accept) begin
      dig_count <= 3'd0;
      frame_idx <= 4'd0;
    end else begin
      if (cmd.conv_step) begin
        dig_count <= dig_count + 3'd1;
      end
      if (cmd.emit_load) begin
        frame_idx <= frame_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      conv_v <= send_sample;
    end else if (cmd.conv_step) begin
      conv_v                   <= quot_w;
      digits[dig_count[1:0]]   <= rem_w[3:0];
    end
  end

  // frame layout: prefix, digits most significant first, suffix
  assign dig_sel    = {1'b0, dig_count} + 4'd4 - frame_idx;
  assign frame_last = (frame_idx == ({1'b0, dig_count} + 4'd7));

  always_comb begin
    frame_byte = crar_pkg::CH_LF;
    if (frame_idx == 4'd0) begin
      frame_byte = crar_pkg::CH_BANG;
    end else if (frame_idx == 4'd1) begin
      frame_byte = crar_pkg::CH_A;
    end else if (frame_idx == 4'd2) begin
      frame_byte = crar_pkg::CH_D;
    end else if (frame_idx == 4'd3) begin
      frame_byte = crar_pkg::CH_C;
    end else if (frame_idx == 4'd4) begin
      frame_byte = crar_pkg::CH_EQ;
    end else if (frame_idx < ({1'b0, dig_count} + 4'd5)) begin
      frame_byte = crar_pkg::CH_ZERO | {4'd0, digits[dig_sel[1:0]]};
    end else if (frame_idx == ({1'b0, dig_count} + 4'd5)) begin
      frame_byte = crar_pkg::CH_HASH;
    end else if (frame_idx == ({1'b0, dig_count} + 4'd6)) begin
      frame_byte = crar_pkg::CH_CR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.stat_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.stat_load) begin
      tx_valid     <= cmd.emit_load;
      tx_byte      <= cmd.emit_load ? frame_byte : 8'd0;
      last         <= cmd.emit_load ? frame_last : 1'b1;
      led_on       <= indicator;
      awaiting_ack <= link_busy;
      sends_done   <= send_count;
    end
  end

  assign status.send_now   = send_now;
  assign status.digit_last = (quot == 9'd0);
  assign status.frame_last = frame_last;
  assign status.out_free   = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_armed_only_busy: assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> link_busy)
    else $error("timer armed with no outstanding request");

  a_count_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    link_busy == (send_count != 4'd0))
    else $error("send count disagrees with request state");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    dig_count <= 3'd4)
    else $error("more than four decimal digits");

  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (frame_idx <= 4'd11))
    else $error("frame index past end of frame");
`endif

endmodule

@@ rtl/command_request_ack_retransmitter.sv @@
// command request / acknowledge retransmitter
//
// input stream: one transaction per received uart byte or timer tick;
//   tuser selects the kind (0 byte, 1 tick), tdata carries the byte and the
//   current 12-bit converter sample
// output stream: one or more transactions per input; a request or timeout
//   that sends gives the frame "!ADC=<decimal>#\r\n" one character per
//   transaction, otherwise a single status-only transaction; tlast marks
//   the final one, tuser flags a frame character
// config port: cfg_we writes cfg_wdata to register cfg_addr;
//   0 is the timeout in ticks, 1 the most frames per request
// sequence: a status-only input is taken and then loads its status result;
//   a sending input is taken, converted to decimal (one digit per cycle
//   through the reciprocal multiplier, 1 to 4 digits) and then emitted
//   as 9 to 12 frame characters
// reset: rst clears the parser, the request state and the indicator and
//   loads timeout 300 and attempts 5
// stalls: results sit in an output register; the next input is taken while
//   the last result waits, and character emission pauses while m_axis_tready
//   is low
module command_request_ack_retransmitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crar_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [crar_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // rx_byte, sample, zero pad
  input  logic                                s_axis_tuser,  // opcode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // tx_byte, led_on, awaiting_ack, sends_done, zero pad
  output logic                                m_axis_tuser,  // tx_valid
  output logic                                m_axis_tlast
);

  crar_pkg::ctrl_cmd_t  cmd;
  crar_pkg::dp_status_t status;

  logic [7:0] tx_byte;
  logic       led_on;
  logic       awaiting_ack;
  logic [3:0] sends_done;

  crar_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  crar_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .opcode       (s_axis_tuser),
    .rx_byte      (s_axis_tdata[7:0]),
    .sample       (s_axis_tdata[19:8]),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .tx_valid     (m_axis_tuser),
    .tx_byte      (tx_byte),
    .last         (m_axis_tlast),
    .led_on       (led_on),
    .awaiting_ack (awaiting_ack),
    .sends_done   (sends_done)
  );

  assign m_axis_tdata = {2'b00, sends_done, awaiting_ack, led_on, tx_byte};

endmodule
